/* rtl/q8gsd_pkg.sv */
// Shared types and IEEE-754 binary32 arithmetic for the q8 group-scaled dot accumulator.
// Used by the front, queue and back modules; depends on nothing else.
package q8gsd_pkg;

    localparam int CodeLanes  = 8;
    localparam logic [31:0] FpDefaultNan = 32'hFFC0_0000;
    localparam logic [31:0] FpPosZero    = 32'h0000_0000;

    // Word handed from the front to the back at each group end
    typedef struct packed {
        logic        clear;
        logic [31:0] group_sum;
        logic [31:0] wgt_scale;
        logic [31:0] act_scale;
    } grp_word_t;

    function automatic logic fp_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic fp_is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [5:0] clz32(input logic [31:0] v);
        logic [5:0] lz;
        lz = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
                lz = 6'(31 - i);
        end
        return lz;
    endfunction

    function automatic logic [5:0] clz48(input logic [47:0] v);
        logic [5:0] lz;
        lz = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
                lz = 6'(47 - i);
        end
        return lz;
    endfunction

    function automatic logic [4:0] clz28(input logic [27:0] v);
        logic [4:0] lz;
        lz = 5'd28;
        for (int i = 0; i < 28; i++)
        begin
            if (v[i])
                lz = 5'(27 - i);
        end
        return lz;
    endfunction

    // Signed 32-bit integer to binary32, round to nearest even
    function automatic logic [31:0] fp_from_int(input logic [31:0] v);
        logic        s;
        logic [31:0] mag;
        logic [5:0]  lz;
        logic [31:0] nrm;
        logic [7:0]  e;
        logic        inc;
        logic [30:0] body;
        s   = v[31];
        mag = s ? (~v + 32'd1) : v;
        lz  = clz32(mag);
        nrm = mag << lz;
        e   = 8'(8'd158 - {2'b00, lz});
        inc = nrm[7] & ((|nrm[6:0]) | nrm[8]);
        body = {e, nrm[30:8]} + {30'd0, inc};
        if (mag == 32'd0)
            return FpPosZero;
        return {s, body};
    endfunction

    // Binary32 multiply, round to nearest even; a NaN in a wins over one in b
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic [23:0]        na;
        logic [23:0]        nb;
        logic [47:0]        p;
        logic [5:0]         lz;
        logic [47:0]        x;
        logic signed [10:0] e;
        logic [10:0]        sh;
        logic               stk;
        logic               inc;
        logic [30:0]        body;
        s   = a[31] ^ b[31];
        na  = {(a[30:23] != 8'd0), a[22:0]};
        nb  = {(b[30:23] != 8'd0), b[22:0]};
        p   = na * nb;
        lz  = clz48(p);
        x   = p << lz;
        e   = $signed({3'b000, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]})
            + $signed({3'b000, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]})
            - 11'sd126 - $signed({5'd0, lz});
        stk = 1'b0;
        // Denormalize results below the normal range
        if (e <= 11'sd0)
        begin
            sh = 11'(11'sd1 - e);
            if (sh >= 11'd48)
            begin
                stk = |x;
                x   = 48'd0;
            end
            else
            begin
                stk = |(x & ((48'd1 << sh) - 48'd1));
                x   = x >> sh;
            end
            e = 11'sd0;
        end
        inc  = x[23] & ((|x[22:0]) | stk | x[24]);
        body = {e[7:0], x[46:24]} + {30'd0, inc};
        if (fp_is_nan(a))
            return a | 32'h0040_0000;
        if (fp_is_nan(b))
            return b | 32'h0040_0000;
        if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_inf(b) && fp_is_zero(a)))
            return FpDefaultNan;
        if (fp_is_inf(a) || fp_is_inf(b))
            return {s, 8'hFF, 23'd0};
        if (fp_is_zero(a) || fp_is_zero(b))
            return {s, 31'd0};
        if (e >= 11'sd255)
            return {s, 8'hFF, 23'd0};
        return {s, body};
    endfunction

    // Binary32 add, round to nearest even; a NaN in a wins over one in b
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  el;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [26:0] x;
        logic [26:0] y;
        logic        stk;
        logic [27:0] sm;
        logic [4:0]  lz;
        logic [4:0]  lzu;
        logic [27:0] sn;
        logic [8:0]  e;
        logic        inc;
        logic [30:0] body;
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        el = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d  = el - es;
        x  = {(big[30:23] != 8'd0), big[22:0], 3'b000};
        y  = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
        // Align the smaller operand, folding lost bits into sticky
        if (d >= 8'd27)
        begin
            stk = |y;
            y   = 27'd0;
        end
        else
        begin
            stk = |(y & ((27'd1 << d) - 27'd1));
            y   = y >> d;
        end
        y[0] = y[0] | stk;
        if (big[31] == sml[31])
            sm = {1'b0, x} + {1'b0, y};
        else
            sm = {1'b0, x} - {1'b0, y};
        lz  = clz28(sm);
        lzu = ({3'b000, lz} > {1'b0, el}) ? el[4:0] : lz;
        sn  = sm << lzu;
        if ({3'b000, lz} > {1'b0, el})
            e = 9'd0;
        else
            e = 9'({1'b0, el} + 9'd1 - {4'd0, lz});
        inc  = sn[3] & ((|sn[2:0]) | sn[4]);
        body = {e[7:0], sn[26:4]} + {30'd0, inc};
        if (fp_is_nan(a))
            return a | 32'h0040_0000;
        if (fp_is_nan(b))
            return b | 32'h0040_0000;
        if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31]))
            return FpDefaultNan;
        if (fp_is_inf(a))
            return a;
        if (fp_is_inf(b))
            return b;
        if (fp_is_zero(a) && fp_is_zero(b))
            return {a[31] & b[31], 31'd0};
        if (sm == 28'd0)
            return FpPosZero;
        if (e >= 9'd255)
            return {big[31], 8'hFF, 23'd0};
        return {big[31], body};
    endfunction

endpackage

/* rtl/q8gsd_front.sv */
// Front end: takes input words, forms the int8 lane dot product and the group sum.
// Emits one group word per group end; uses q8gsd_pkg.
module q8gsd_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  clear_accum,
    input  logic [63:0]           act_codes,
    input  logic [63:0]           weight_codes,
    input  logic                  group_end,
    input  logic [31:0]           wgt_scale,
    input  logic [31:0]           act_scale,
    output logic                  grp_push,
    output q8gsd_pkg::grp_word_t  grp_word,
    input  logic                  grp_full
);
    import q8gsd_pkg::*;

    logic [31:0] group_sum_reg;
    logic [31:0] group_sum_next;
    logic        clear_pend_reg;
    logic        clear_pend_next;
    logic        take;
    logic [31:0] dot;
    logic [31:0] sum_now;

    assign full = grp_full;
    assign take = push && !grp_full;

    // Add the signed lane products
    always_comb
    begin
        logic signed [15:0] prod;
        dot = 32'd0;
        for (int i = 0; i < CodeLanes; i++)
        begin
            prod = $signed(act_codes[8*i +: 8]) * $signed(weight_codes[8*i +: 8]);
            dot  = dot + {{16{prod[15]}}, prod};
        end
    end

    assign sum_now = group_sum_reg + dot;

    // Hand the closed group to the back end
    assign grp_push               = take && group_end;
    assign grp_word.clear         = clear_pend_reg | clear_accum;
    assign grp_word.group_sum     = sum_now;
    assign grp_word.wgt_scale     = wgt_scale;
    assign grp_word.act_scale     = act_scale;

    // Advance the group sum; hold a clear until its group closes
    always_comb
    begin
        group_sum_next  = group_sum_reg;
        clear_pend_next = clear_pend_reg;
        if (take)
        begin
            if (group_end)
            begin
                group_sum_next  = 32'd0;
                clear_pend_next = 1'b0;
            end
            else
            begin
                group_sum_next  = sum_now;
                clear_pend_next = clear_pend_reg | clear_accum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_sum_reg  <= 32'd0;
            clear_pend_reg <= 1'b0;
        end
        else
        begin
            group_sum_reg  <= group_sum_next;
            clear_pend_reg <= clear_pend_next;
        end
    end

endmodule

/* rtl/q8gsd_queue.sv */
// Short queue of group words between front and back ends.
// Uses q8gsd_pkg for the word type.
module q8gsd_queue #(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  q8gsd_pkg::grp_word_t  wr_word,
    output logic                  full,
    input  logic                  rd_en,
    output q8gsd_pkg::grp_word_t  rd_word,
    output logic                  empty
);
    import q8gsd_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    grp_word_t         slot_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = count_reg == CntW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_word = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_word;
    end

endmodule

/* rtl/q8gsd_back.sv */
// Back end: converts the group sum, scales it twice and adds it to the fp32 accumulator.
// Holds the result word for the output side; uses q8gsd_pkg arithmetic.
module q8gsd_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  grp_empty,
    input  q8gsd_pkg::grp_word_t  grp_word,
    output logic                  grp_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [31:0]           accumulated_sum
);
    import q8gsd_pkg::*;

    typedef enum logic [1:0] {
        S_CVT,
        S_MUL_W,
        S_MUL_A,
        S_ADD
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [31:0] work_reg;
    logic [31:0] work_next;
    logic [31:0] wscale_reg;
    logic [31:0] ascale_reg;
    logic        clear_reg;
    logic [31:0] accum_reg;
    logic [31:0] accum_next;
    logic [31:0] out_reg;
    logic [31:0] out_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        load;

    assign out_free        = !out_valid_reg || pop;
    assign load            = (state_reg == S_CVT) && !grp_empty;
    assign grp_pop         = load;
    assign empty           = !out_valid_reg;
    assign accumulated_sum = out_reg;

    // Step through convert, two scalings and the accumulate
    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        accum_next     = accum_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        case (state_reg)
            S_CVT:
            begin
                if (load)
                begin
                    work_next  = fp_from_int(grp_word.group_sum);
                    state_next = S_MUL_W;
                end
            end
            S_MUL_W:
            begin
                work_next  = fp_mul(work_reg, wscale_reg);
                state_next = S_MUL_A;
            end
            S_MUL_A:
            begin
                work_next  = fp_mul(work_reg, ascale_reg);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    accum_next     = fp_add(clear_reg ? FpPosZero : accum_reg, work_reg);
                    out_next       = accum_next;
                    out_valid_next = 1'b1;
                    state_next     = S_CVT;
                end
            end
            default:
            begin
                state_next = S_CVT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CVT;
            accum_reg     <= FpPosZero;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            accum_reg     <= accum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold operands and the result word
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        out_reg  <= out_next;
        if (load)
        begin
            wscale_reg <= grp_word.wgt_scale;
            ascale_reg <= grp_word.act_scale;
            clear_reg  <= grp_word.clear;
        end
    end

endmodule

/* rtl/q8_group_scaled_dot_accumulate.sv */
// A group-end word's result passes the queue write, convert, two scalings and accumulate
// (which waits for a free result register); other words leave no result. The block takes
// one word per cycle while full is low; the fp32 back end handles one group end at a
// time, and the queue (QUEUE_DEPTH words) absorbs bursts of closely spaced group ends.
// Reset (rst_n, async, active low) clears the group sum, the accumulator to +0 and
// empties the queue and the result register.
module q8_group_scaled_dot_accumulate #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        clear_accum,
    input  logic [63:0] act_codes,
    input  logic [63:0] weight_codes,
    input  logic        group_end,
    input  logic [31:0] wgt_scale,
    input  logic [31:0] act_scale,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] accumulated_sum
);
    import q8gsd_pkg::*;

    grp_word_t fq_word;
    grp_word_t qb_word;
    logic      fq_push;
    logic      q_full;
    logic      q_empty;
    logic      qb_pop;

    // Classify and sum incoming words
    q8gsd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .clear_accum  (clear_accum),
        .act_codes    (act_codes),
        .weight_codes (weight_codes),
        .group_end    (group_end),
        .wgt_scale    (wgt_scale),
        .act_scale    (act_scale),
        .grp_push     (fq_push),
        .grp_word     (fq_word),
        .grp_full     (q_full)
    );

    // Decouple the two ends
    q8gsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_word (fq_word),
        .full    (q_full),
        .rd_en   (qb_pop),
        .rd_word (qb_word),
        .empty   (q_empty)
    );

    // Run the float sequence
    q8gsd_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .grp_empty       (q_empty),
        .grp_word        (qb_word),
        .grp_pop         (qb_pop),
        .empty           (empty),
        .pop             (pop),
        .accumulated_sum (accumulated_sum)
    );

endmodule

/* verif/tb_q8_group_scaled_dot_accumulate.sv */
// Testbench for q8_group_scaled_dot_accumulate: directed table, then random groups,
// checked against an integer-exact fp32 predictor. Depends only on the block's RTL.
module tb_q8_group_scaled_dot_accumulate;

    localparam logic [31:0] SpOne     = 32'h3F80_0000;
    localparam logic [31:0] SpHalf    = 32'h3F00_0000;
    localparam logic [31:0] SpPosInf  = 32'h7F80_0000;
    localparam logic [31:0] SpNegInf  = 32'hFF80_0000;
    localparam logic [31:0] SpMaxNorm = 32'h7F7F_FFFF;
    localparam logic [31:0] SpNegZero = 32'h8000_0000;
    localparam logic [31:0] SpDefNan  = 32'hFFC0_0000;
    localparam int          NumRandom = 830;

    typedef struct {
        logic        clear;
        logic [63:0] acts;
        logic [63:0] wts;
        logic        gend;
        logic [31:0] ws;
        logic [31:0] as_;
        logic        typed;
        logic [31:0] typed_sum;
    } dot_word_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        clear_accum;
    logic [63:0] act_codes;
    logic [63:0] weight_codes;
    logic        group_end;
    logic [31:0] wgt_scale;
    logic [31:0] act_scale;
    logic        empty;
    logic        pop;
    logic [31:0] accumulated_sum;

    dot_word_t   words[$];
    logic [31:0] sum_expect_q[$];
    logic [31:0] model_group_sum;
    logic [31:0] model_accum;
    int          send_idx;
    int          taken_cnt;
    int          err_cnt;
    int          cyc;

    q8_group_scaled_dot_accumulate dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .clear_accum(clear_accum), .act_codes(act_codes), .weight_codes(weight_codes),
        .group_end(group_end), .wgt_scale(wgt_scale), .act_scale(act_scale),
        .empty(empty), .pop(pop), .accumulated_sum(accumulated_sum)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Round a magnitude m * 2^e to binary32, nearest even
    function automatic logic [31:0] sp_pack(input logic s, input int e, input logic [127:0] m);
        int           p;
        int           bexp;
        int           lsb;
        int           r;
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] half;
        longint       bits;
        p = -1;
        for (int i = 0; i < 128; i++)
        begin
            if (m[i])
                p = i;
        end
        if (p < 0)
            return {s, 31'd0};
        bexp = p + e + 127;
        lsb  = (bexp >= 1) ? p + e - 23 : -149;
        r    = lsb - e;
        if (r <= 0)
            q = m << (-r);
        else if (r >= 128)
            q = '0;
        else
        begin
            q    = m >> r;
            rem  = m & ((128'd1 << r) - 128'd1);
            half = 128'd1 << (r - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 128'd1;
        end
        bits = (bexp >= 1) ? ((longint'(bexp - 1) << 23) + longint'(q[63:0])) :
                             longint'(q[63:0]);
        if (bits >= 64'h7F80_0000)
            return {s, 8'hFF, 23'd0};
        return {s, bits[30:0]};
    endfunction

    function automatic logic sp_nan(input logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] != 23'd0;
    endfunction

    function automatic logic sp_inf(input logic [31:0] a);
        return a[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic [23:0] sp_mant(input logic [31:0] a);
        return {a[30:23] != 8'd0, a[22:0]};
    endfunction

    function automatic int sp_exp(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
    endfunction

    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (sp_nan(a))
            return a | 32'h0040_0000;
        if (sp_nan(b))
            return b | 32'h0040_0000;
        if ((sp_inf(a) && b[30:0] == 0) || (sp_inf(b) && a[30:0] == 0))
            return SpDefNan;
        if (sp_inf(a) || sp_inf(b))
            return {s, 8'hFF, 23'd0};
        return sp_pack(s, sp_exp(a) + sp_exp(b), 128'(sp_mant(a) * 48'(sp_mant(b))));
    endfunction

    function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]  hi;
        logic [31:0]  lo;
        int           d;
        int           e;
        logic [127:0] mh;
        logic [127:0] ml;
        if (sp_nan(a))
            return a | 32'h0040_0000;
        if (sp_nan(b))
            return b | 32'h0040_0000;
        if (sp_inf(a) && sp_inf(b) && a[31] != b[31])
            return SpDefNan;
        if (sp_inf(a))
            return a;
        if (sp_inf(b))
            return b;
        if (a[30:0] == 0 && b[30:0] == 0)
            return {a[31] & b[31], 31'd0};
        hi = (sp_exp(a) >= sp_exp(b)) ? a : b;
        lo = (sp_exp(a) >= sp_exp(b)) ? b : a;
        d  = sp_exp(hi) - sp_exp(lo);
        // Far-apart operands: the small one only matters as a sticky bit
        if (d > 40)
        begin
            mh = 128'(sp_mant(hi)) << 40;
            ml = (sp_mant(lo) != 0) ? 128'd1 : 128'd0;
            e  = sp_exp(hi) - 40;
        end
        else
        begin
            mh = 128'(sp_mant(hi)) << d;
            ml = 128'(sp_mant(lo));
            e  = sp_exp(lo);
        end
        if (hi[31] == lo[31])
            return sp_pack(hi[31], e, mh + ml);
        if (mh == ml)
            return 32'd0;
        if (mh > ml)
            return sp_pack(hi[31], e, mh - ml);
        return sp_pack(lo[31], e, ml - mh);
    endfunction

    // Advance the group sum and accumulator; return 1 with the new sum at group end
    function automatic logic predict_accum(input logic clr, input logic [63:0] acts,
                                           input logic [63:0] wts, input logic gend,
                                           input logic [31:0] ws, input logic [31:0] as_,
                                           output logic [31:0] sum);
        int          prod;
        logic [31:0] mag;
        logic [31:0] dot;
        if (clr)
            model_accum = 32'd0;
        for (int l = 0; l < 8; l++)
        begin
            prod = int'($signed(acts[8*l +: 8])) * int'($signed(wts[8*l +: 8]));
            model_group_sum = model_group_sum + 32'(prod);
        end
        if (!gend)
            return 1'b0;
        mag = model_group_sum[31] ? -model_group_sum : model_group_sum;
        dot = sp_pack(model_group_sum[31], 0, 128'(mag));
        model_accum = sp_add(model_accum, sp_mul(sp_mul(dot, ws), as_));
        model_group_sum = 32'd0;
        sum = model_accum;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %08h want %08h at cycle %0d", what, got, want, cyc);
        err_cnt++;
    endtask

    function automatic logic [31:0] rand_scale();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 9) < 8)
            v[30:23] = 8'($urandom_range(100, 140));
        return v;
    endfunction

    function automatic void add_word(input logic clr, input logic [63:0] acts,
                                     input logic [63:0] wts, input logic gend,
                                     input logic [31:0] ws, input logic [31:0] as_,
                                     input logic typed, input logic [31:0] typed_sum);
        dot_word_t w;
        w = '{clr, acts, wts, gend, ws, as_, typed, typed_sum};
        words.push_back(w);
    endfunction

    // Build the directed table and the random groups
    initial
    begin
        int glen;
        add_word(1'b0, '0, '0, 1'b1, SpOne, SpOne, 1'b1, 32'd0);
        add_word(1'b0, {8{8'h7F}}, {8{8'h7F}}, 1'b1, SpOne, SpOne, 1'b0, 32'd0);
        add_word(1'b1, {8{8'h80}}, {8{8'h80}}, 1'b1, SpOne, SpOne, 1'b1, 32'h4800_0000);
        add_word(1'b0, {8{8'h80}}, {8{8'h7F}}, 1'b1, SpOne, SpHalf, 1'b0, 32'd0);
        add_word(1'b0, {8{8'h7F}}, {8{8'h80}}, 1'b0, '0, '0, 1'b0, 32'd0);
        add_word(1'b1, {8{8'hFF}}, {8{8'h01}}, 1'b0, '1, '1, 1'b0, 32'd0);
        add_word(1'b0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, '0, '0,
                 1'b0, 32'd0);
        add_word(1'b0, 64'h1, 64'h1, 1'b1, SpHalf, 32'hC040_0000, 1'b0, 32'd0);
        // NaN scale propagates quieted
        add_word(1'b1, 64'h1, 64'h1, 1'b1, 32'h7F80_0001, SpOne, 1'b1, 32'h7FC0_0001);
        // Infinity times zero
        add_word(1'b1, '0, '0, 1'b1, SpPosInf, SpOne, 1'b1, SpDefNan);
        add_word(1'b1, 64'h1, 64'h1, 1'b1, SpPosInf, SpOne, 1'b1, SpPosInf);
        add_word(1'b0, 64'h1, 64'h1, 1'b1, SpNegInf, SpOne, 1'b1, SpDefNan);
        // Overflow to infinity
        add_word(1'b1, {8{8'h7F}}, {8{8'h7F}}, 1'b1, SpMaxNorm, SpMaxNorm, 1'b1, SpPosInf);
        // Tiniest subnormal halved rounds to zero
        add_word(1'b1, 64'h1, 64'h1, 1'b1, 32'h0000_0001, SpHalf, 1'b1, 32'd0);
        add_word(1'b0, 64'h3, 64'h5, 1'b1, 32'h0000_0001, SpOne, 1'b0, 32'd0);
        // Negative zero contribution into positive zero
        add_word(1'b1, '0, '0, 1'b1, SpNegZero, SpOne, 1'b1, 32'd0);
        add_word(1'b0, 64'h1, 64'hFF, 1'b1, SpNegZero, SpNegZero, 1'b0, 32'd0);
        add_word(1'b1, '1, '1, 1'b0, '0, '0, 1'b0, 32'd0);
        add_word(1'b0, 64'h7F, 64'h80, 1'b1, '1, '1, 1'b0, 32'd0);
        add_word(1'b1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1,
                 32'h0080_0000, SpHalf, 1'b0, 32'd0);
        // Random groups, mostly four words long, with some odd lengths
        while (words.size() < 20 + NumRandom)
        begin
            glen = ($urandom_range(0, 9) < 8) ? 4 : $urandom_range(1, 9);
            for (int k = 0; k < glen; k++)
                add_word(k == 0 && $urandom_range(0, 9) == 0 || $urandom_range(0, 49) == 0,
                         {$urandom, $urandom}, {$urandom, $urandom}, k == glen - 1,
                         rand_scale(), rand_scale(), 1'b0, 32'd0);
        end
    end

    // Drive words and pops; idle about one cycle in five outside a quiet stretch
    always @(posedge clk)
    begin
        int nxt;
        logic idle;
        cyc++;
        if (rst_n)
        begin
            nxt = send_idx;
            if (push && !full)
                nxt++;
            send_idx = nxt;
            idle = (cyc < 200 || cyc > 600) && $urandom_range(0, 99) < 20;
            if (nxt < words.size() && !idle)
            begin
                push         <= 1'b1;
                clear_accum  <= words[nxt].clear;
                act_codes    <= words[nxt].acts;
                weight_codes <= words[nxt].wts;
                group_end    <= words[nxt].gend;
                wgt_scale    <= words[nxt].ws;
                act_scale    <= words[nxt].as_;
            end
            else
                push <= 1'b0;
            pop <= (cyc >= 200 && cyc <= 600) || $urandom_range(0, 99) >= 20;
        end
    end

    // Predict on every accepted word
    always @(posedge clk)
    begin
        logic [31:0] sum;
        if (rst_n && push && !full)
        begin
            if (predict_accum(clear_accum, act_codes, weight_codes, group_end,
                              wgt_scale, act_scale, sum))
                sum_expect_q.push_back(words[taken_cnt].typed ?
                                       words[taken_cnt].typed_sum : sum);
            taken_cnt++;
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (sum_expect_q.size() == 0)
                report_mismatch("unexpected result", accumulated_sum, 32'd0);
            else if (accumulated_sum !== sum_expect_q[0])
                report_mismatch("accumulated_sum", accumulated_sum, sum_expect_q.pop_front());
            else
                void'(sum_expect_q.pop_front());
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        clear_accum = 1'b0;
        act_codes = '0;
        weight_codes = '0;
        group_end = 1'b0;
        wgt_scale = '0;
        act_scale = '0;
        model_group_sum = '0;
        model_accum = '0;
        send_idx = 0;
        taken_cnt = 0;
        err_cnt = 0;
        cyc = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (words.size() > 0 && taken_cnt == words.size());
        wait (sum_expect_q.size() == 0);
        repeat (20) @(posedge clk);
        if (err_cnt == 0 && sum_expect_q.size() == 0)
            $display("tb_q8_group_scaled_dot_accumulate: done, clean");
        else
            $display("tb_q8_group_scaled_dot_accumulate: done, errors");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin
        #4000000;
        $display("tb_q8_group_scaled_dot_accumulate: done, errors");
        $finish;
    end

endmodule
